>>> rtl/core/xeu_pkg.sv
// Shared types, entity tables and match function for the XML entity unescaper.
package xeu_pkg;

  localparam int NUM_ENT  = 5;
  localparam int ENT_MAX  = 6;
  localparam int PEND_MAX = 5;

  localparam logic [7:0] AMP = 8'h26;

  localparam logic [7:0] ENT_TEXT [NUM_ENT][ENT_MAX] = '{
    '{8'h26, 8'h71, 8'h75, 8'h6F, 8'h74, 8'h3B},
    '{8'h26, 8'h6C, 8'h74, 8'h3B, 8'h00, 8'h00},
    '{8'h26, 8'h67, 8'h74, 8'h3B, 8'h00, 8'h00},
    '{8'h26, 8'h61, 8'h70, 8'h6F, 8'h73, 8'h3B},
    '{8'h26, 8'h61, 8'h6D, 8'h70, 8'h3B, 8'h00}
  };
  localparam logic [2:0] ENT_LEN [NUM_ENT] = '{3'd6, 3'd4, 3'd4, 3'd6, 3'd5};
  localparam logic [7:0] ENT_CHAR [NUM_ENT] = '{8'h22, 8'h3C, 8'h3E, 8'h27, 8'h26};

  typedef logic [PEND_MAX-1:0][7:0] pend_t;

  typedef struct packed {
    logic [7:0] in_byte;
    logic       in_last;
  } in_t;

  typedef struct packed {
    logic [7:0] out_byte;
    logic       out_last;
  } out_t;

  // One request for the back end: the first flush_cnt held bytes, then an
  // optional tail byte.
  typedef struct packed {
    pend_t      pend;
    logic [2:0] flush_cnt;
    logic       has_tail;
    logic [7:0] tail;
    logic       last;
  } cmd_t;

  typedef struct packed {
    logic       hit;
    logic       prefix;
    logic [7:0] chr;
  } match_t;

  // Compares the held bytes plus the new byte against every entity.
  function automatic match_t classify(input pend_t pend, input logic [2:0] cnt,
                                      input logic [7:0] b);
    logic [7:0] cand [ENT_MAX];
    logic [2:0] len;
    logic       eq;
    match_t     m;
    m   = '0;
    len = cnt + 3'd1;
    for (int i = 0; i < ENT_MAX; i++) begin
      if (i < PEND_MAX && 3'(i) < cnt) begin
        cand[i] = pend[i];
      end else if (3'(i) == cnt) begin
        cand[i] = b;
      end else begin
        cand[i] = 8'h00;
      end
    end
    for (int e = NUM_ENT - 1; e >= 0; e--) begin
      eq = (len <= ENT_LEN[e]);
      for (int i = 0; i < ENT_MAX; i++) begin
        if (3'(i) < len && cand[i] != ENT_TEXT[e][i]) begin
          eq = 1'b0;
        end
      end
      if (eq) begin
        if (len == ENT_LEN[e]) begin
          m.hit = 1'b1;
          m.chr = ENT_CHAR[e];
        end else begin
          m.prefix = 1'b1;
        end
      end
    end
    return m;
  endfunction

endpackage

>>> rtl/core/xml_entity_unescape.sv
// Streaming XML predefined-entity unescaper: replaces &quot; &lt; &gt; &apos; and &amp;
// with their characters in a single left-to-right pass, one text byte per request.
// Input requests are taken at one per cycle while in_full is low; each is classified
// in the cycle it arrives and leaves at most one request in a queue of QUEUE_DEPTH
// entries. The result side delivers one byte per cycle in which out_pop is high, so an
// input byte yields one output byte, a failed partial match up to six (the held bytes
// plus the new one); in_full rises only when that queue fills behind a stalled or
// busy result side. A byte that only extends a partial match produces no result.
module xml_entity_unescape #(
  parameter int QUEUE_DEPTH = 4
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_push,
  output logic          in_full,
  input  xeu_pkg::in_t  in_data,
  output logic          out_empty,
  input  logic          out_pop,
  output xeu_pkg::out_t out_data
);

  logic          accept;
  logic          cmd_valid;
  xeu_pkg::cmd_t cmd;
  logic          q_empty;
  logic          head_done;
  xeu_pkg::cmd_t head;

  assign accept = in_push && !in_full;

  xeu_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .accept    (accept),
    .in_data   (in_data),
    .cmd_valid (cmd_valid),
    .cmd       (cmd)
  );

  xeu_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk     (clk),
    .rst_n   (rst_n),
    .wr_en   (cmd_valid),
    .wr_data (cmd),
    .full    (in_full),
    .rd_en   (head_done),
    .empty   (q_empty),
    .rd_data (head)
  );

  xeu_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .head_empty (q_empty),
    .head       (head),
    .head_done  (head_done),
    .out_empty  (out_empty),
    .out_pop    (out_pop),
    .out_data   (out_data)
  );

endmodule

>>> rtl/core/xeu_front.sv
// Front end: holds the partial entity match and turns input bytes into requests.
module xeu_front (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          accept,
  input  xeu_pkg::in_t  in_data,
  output logic          cmd_valid,
  output xeu_pkg::cmd_t cmd
);

  xeu_pkg::pend_t pend_r, pend_nxt;
  logic [2:0]     cnt_r, cnt_nxt;
  xeu_pkg::match_t m;
  logic [7:0]     b;
  logic           last;

  assign b    = in_data.in_byte;
  assign last = in_data.in_last;
  assign m    = xeu_pkg::classify(pend_r, cnt_r, b);

  always_comb begin
    pend_nxt      = pend_r;
    cnt_nxt       = cnt_r;
    cmd.pend      = pend_r;
    cmd.flush_cnt = 3'd0;
    cmd.has_tail  = 1'b0;
    cmd.tail      = b;
    cmd.last      = last;
    if (cnt_r != 3'd0 && m.hit) begin
      cnt_nxt      = 3'd0;
      cmd.has_tail = 1'b1;
      cmd.tail     = m.chr;
    end else if (cnt_r != 3'd0 && m.prefix && cnt_r < 3'(xeu_pkg::PEND_MAX)) begin
      if (last) begin
        // The string ends inside a partial match: everything goes out as is.
        cnt_nxt       = 3'd0;
        cmd.flush_cnt = cnt_r;
        cmd.has_tail  = 1'b1;
      end else begin
        for (int i = 0; i < xeu_pkg::PEND_MAX; i++) begin
          if (3'(i) == cnt_r) begin
            pend_nxt[i] = b;
          end
        end
        cnt_nxt = cnt_r + 3'd1;
      end
    end else begin
      cmd.flush_cnt = cnt_r;
      if (b != xeu_pkg::AMP || last) begin
        cnt_nxt      = 3'd0;
        cmd.has_tail = 1'b1;
      end else begin
        pend_nxt[0] = b;
        cnt_nxt     = 3'd1;
      end
    end
  end

  assign cmd_valid = accept && (cmd.flush_cnt != 3'd0 || cmd.has_tail);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= 3'd0;
    end else if (accept) begin
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      pend_r <= pend_nxt;
    end
  end

endmodule

>>> rtl/core/xeu_queue.sv
// Short request queue between the front and back ends.
module xeu_queue #(
  parameter int DEPTH = 4
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          wr_en,
  input  xeu_pkg::cmd_t wr_data,
  output logic          full,
  input  logic          rd_en,
  output logic          empty,
  output xeu_pkg::cmd_t rd_data
);

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  xeu_pkg::cmd_t mem [DEPTH];
  logic [PW-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PW-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CW-1:0] count_r, count_nxt;
  logic          do_wr, do_rd;

  assign full    = (count_r == CW'(DEPTH));
  assign empty   = (count_r == '0);
  assign do_wr   = wr_en && !full;
  assign do_rd   = rd_en && !empty;
  assign rd_data = mem[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (do_wr) begin
      wr_ptr_nxt = (wr_ptr_r == PW'(DEPTH - 1)) ? '0 : wr_ptr_r + PW'(1);
    end
    if (do_rd) begin
      rd_ptr_nxt = (rd_ptr_r == PW'(DEPTH - 1)) ? '0 : rd_ptr_r + PW'(1);
    end
    if (do_wr && !do_rd) begin
      count_nxt = count_r + CW'(1);
    end else if (do_rd && !do_wr) begin
      count_nxt = count_r - CW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_wr) begin
      mem[wr_ptr_r] <= wr_data;
    end
  end

endmodule

>>> rtl/core/xeu_back.sv
// Back end: walks through one request and presents its bytes one per pop.
module xeu_back (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          head_empty,
  input  xeu_pkg::cmd_t head,
  output logic          head_done,
  output logic          out_empty,
  input  logic          out_pop,
  output xeu_pkg::out_t out_data
);

  logic [2:0] idx_r, idx_nxt;
  logic [2:0] total;
  logic       at_end;

  assign total     = head.flush_cnt + {2'b00, head.has_tail};
  assign at_end    = (idx_r == total - 3'd1);
  assign out_empty = head_empty;
  assign head_done = out_pop && !head_empty && at_end;

  always_comb begin
    out_data.out_byte = head.tail;
    if (idx_r < head.flush_cnt) begin
      out_data.out_byte = head.pend[idx_r];
    end
    out_data.out_last = head.last && at_end;
  end

  always_comb begin
    idx_nxt = idx_r;
    if (out_pop && !head_empty) begin
      idx_nxt = at_end ? 3'd0 : idx_r + 3'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      idx_r <= 3'd0;
    end else begin
      idx_r <= idx_nxt;
    end
  end

endmodule
